// File: rtl/mailbox_ram_access_bridge_unit_defines.svh
// Assertion macros shared by the bridge RTL.
`ifndef MAILBOX_RAM_ACCESS_BRIDGE_UNIT_DEFINES_SVH
`define MAILBOX_RAM_ACCESS_BRIDGE_UNIT_DEFINES_SVH
`ifndef SYNTH
// Antecedent holds in a cycle, consequent must hold in the same cycle.
`define MRAB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bridge check failed");
// Antecedent holds in a cycle, consequent must hold in the next cycle.
`define MRAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bridge check failed");
`else
`define MRAB_ASSERT_SAME(label, clk, rst, ante, cons)
`define MRAB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mrab_pkg.sv
package mrab_pkg;

  localparam logic [15:0] POLL_LIMIT_RESET  = 16'd10000;
  localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;
  localparam logic [14:0] OFFSET_MASK       = 15'h7FFE;
  localparam logic [15:0] TIMEOUT_WORD      = 16'hFFFF;

  // Function codes of an input item.
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_POLL   = 1'b1;

  // Register indexes on the configuration port (taken from paddr[2]).
  localparam logic REG_POLL_LIMIT  = 1'b0;
  localparam logic REG_RETRY_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_BUSY = 2'd1
  } phase_t;

  typedef struct packed {
    logic        func;
    logic        access_write;
    logic        access_byte;
    logic [14:0] offset;
    logic [15:0] write_data;
    logic        rsp_valid;
    logic [15:0] rsp_data;
  } mrab_in_t;

  typedef struct packed {
    logic        req_strobe;
    logic [32:0] req_value;
    logic        rsp_clear;
    logic        access_done;
    logic [15:0] read_result;
    logic        timed_out;
  } mrab_out_t;

  typedef struct packed {
    logic [15:0] poll_limit;
    logic [2:0]  retry_limit;
  } mrab_cfg_t;

  typedef struct packed {
    logic busy;
  } mrab_status_t;

  // Request word: bit 0 valid, bit 1 write, bits 16:2 word offset, bits 32:17 data.
  function automatic logic [32:0] make_req(logic [14:0] off, logic wr, logic [15:0] data);
    return {data, off & OFFSET_MASK, wr, 1'b1};
  endfunction

endpackage

// File: rtl/mailbox_ram_access_bridge_unit.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------
// item      | in        | item_valid / item_ready     | mrab_pkg::mrab_in_t
// result    | out       | result_valid / result_ready | mrab_pkg::mrab_out_t
// config    | in        | APB psel/penable/pready     | paddr[2:0], pwdata 32 bits
//
// Every accepted transaction yields exactly one result, which the output stage registers.
// A new item is taken in every cycle while the result register is empty or
// being emptied in the same cycle, so the sustained rate is one item per clock.
// Only a stalled result register (result_valid high, result_ready low) holds
// item_ready low. rst is synchronous and active high; it returns the bridge to
// idle with zero counters and the limits to 10000 polls and 3 attempts.

`include "mailbox_ram_access_bridge_unit_defines.svh"

module mailbox_ram_access_bridge_unit (
  input  logic                clk,
  input  logic                rst,
  // Item channel.
  input  logic                item_valid,
  output logic                item_ready,
  input  mrab_pkg::mrab_in_t  item,
  // Result channel.
  output logic                result_valid,
  input  logic                result_ready,
  output mrab_pkg::mrab_out_t result,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  mrab_pkg::mrab_cfg_t    cfg;
  mrab_pkg::mrab_out_t    res;
  mrab_pkg::mrab_status_t status;
  logic                   step;
  logic                   cfg_write;

  // The result register frees up either when it is empty or when its current
  // transaction is taken this cycle, so the item side never waits on a bubble.
  assign item_ready = !result_valid || result_ready;
  assign step       = item_valid && item_ready;

  // Configuration registers. Only paddr[2] selects the register; the
  // two registers sit at byte addresses 0 and 4.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_limit  <= mrab_pkg::POLL_LIMIT_RESET;
      cfg.retry_limit <= mrab_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        mrab_pkg::REG_POLL_LIMIT:  cfg.poll_limit  <= pwdata[15:0];
        mrab_pkg::REG_RETRY_LIMIT: cfg.retry_limit <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mrab_pkg::REG_POLL_LIMIT:  prdata = {16'h0000, cfg.poll_limit};
      mrab_pkg::REG_RETRY_LIMIT: prdata = {29'h0, cfg.retry_limit};
      default:                   prdata = '0;
    endcase
  end

  // The core holds the transfer state and works out each result in the cycle
  // the item is accepted; the output stage registers it.
  mrab_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .res    (res),
    .status (status)
  );

  mrab_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (step),
    .res          (res),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

  // A host access taken while idle must leave the bridge busy.
  `MRAB_ASSERT_NEXT(a_access_starts, clk, rst, step && !status.busy && item.func == mrab_pkg::FUNC_ACCESS, status.busy)
  // A timeout always finishes the access and clears the request mailbox.
  `MRAB_ASSERT_SAME(a_timeout_shape, clk, rst, result_valid && result.timed_out, result.access_done && result.req_strobe && result.req_value == '0)
  // No request word is shown unless the request mailbox is written.
  `MRAB_ASSERT_SAME(a_req_quiet, clk, rst, result_valid && !result.req_strobe, result.req_value == '0)
  // Clearing the response mailbox always comes with a request mailbox write.
  `MRAB_ASSERT_SAME(a_clear_with_req, clk, rst, result_valid && result.rsp_clear, result.req_strobe)

endmodule

// File: rtl/mrab_core.sv
module mrab_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  mrab_pkg::mrab_in_t    item,
  input  mrab_pkg::mrab_cfg_t   cfg,
  output mrab_pkg::mrab_out_t   res,
  output mrab_pkg::mrab_status_t status
);

  mrab_pkg::phase_t phase, phase_next;
  logic [15:0] poll_count, poll_count_next;
  logic [2:0]  attempt_count, attempt_count_next;
  logic [32:0] pending_request, pending_request_next;
  logic        lane_odd, lane_odd_next;
  logic        byte_mode, byte_mode_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        rmw_pending, rmw_pending_next;

  logic [15:0] plim;
  logic [2:0]  rlim;
  logic [16:0] poll_inc;
  logic [3:0]  attempt_inc;
  logic        end_xfer;
  logic        end_tmo;
  logic [15:0] end_word;
  logic [15:0] merged;
  logic [15:0] rd_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= mrab_pkg::PHASE_IDLE;
      poll_count      <= '0;
      attempt_count   <= '0;
      pending_request <= '0;
      lane_odd        <= 1'b0;
      byte_mode       <= 1'b0;
      held_byte       <= '0;
      rmw_pending     <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      poll_count      <= poll_count_next;
      attempt_count   <= attempt_count_next;
      pending_request <= pending_request_next;
      lane_odd        <= lane_odd_next;
      byte_mode       <= byte_mode_next;
      held_byte       <= held_byte_next;
      rmw_pending     <= rmw_pending_next;
    end
  end

  assign plim        = (cfg.poll_limit == '0) ? 16'd1 : cfg.poll_limit;
  assign rlim        = (cfg.retry_limit == '0) ? 3'd1 : cfg.retry_limit;
  assign poll_inc    = {1'b0, poll_count} + 17'd1;
  assign attempt_inc = {1'b0, attempt_count} + 4'd1;
  assign merged      = lane_odd ? {end_word[15:8], held_byte} : {held_byte, end_word[7:0]};
  assign rd_sel      = !byte_mode ? end_word :
                       lane_odd   ? {8'h00, end_word[7:0]} : {8'h00, end_word[15:8]};
  assign status.busy = (phase == mrab_pkg::PHASE_BUSY);

  always_comb begin
    phase_next           = phase;
    poll_count_next      = poll_count;
    attempt_count_next   = attempt_count;
    pending_request_next = pending_request;
    lane_odd_next        = lane_odd;
    byte_mode_next       = byte_mode;
    held_byte_next       = held_byte;
    rmw_pending_next     = rmw_pending;
    res                  = '0;
    end_xfer             = 1'b0;
    end_tmo              = 1'b0;
    end_word             = item.rsp_data;

    unique case (phase)
      mrab_pkg::PHASE_IDLE: begin
        if (item.func == mrab_pkg::FUNC_ACCESS) begin
          byte_mode_next     = item.access_byte;
          lane_odd_next      = item.offset[0];
          held_byte_next     = item.write_data[7:0];
          rmw_pending_next   = item.access_byte & item.access_write;
          if (item.access_byte && item.access_write) begin
            pending_request_next = mrab_pkg::make_req(item.offset, 1'b0, 16'h0000);
          end else begin
            pending_request_next = mrab_pkg::make_req(item.offset, item.access_write,
                                     item.access_write ? item.write_data : 16'h0000);
          end
          poll_count_next    = '0;
          attempt_count_next = '0;
          phase_next         = mrab_pkg::PHASE_BUSY;
          res.req_strobe     = 1'b1;
          res.req_value      = pending_request_next;
        end
      end
      mrab_pkg::PHASE_BUSY: begin
        if (item.func == mrab_pkg::FUNC_POLL) begin
          if (item.rsp_valid) begin
            res.req_strobe = 1'b1;
            res.rsp_clear  = 1'b1;
            end_xfer       = 1'b1;
          end else if (poll_inc < {1'b0, plim}) begin
            poll_count_next = poll_inc[15:0];
          end else begin
            poll_count_next = '0;
            res.req_strobe  = 1'b1;
            if (attempt_inc < {1'b0, rlim}) begin
              attempt_count_next = attempt_inc[2:0];
              res.req_value      = pending_request;
            end else begin
              end_xfer = 1'b1;
              end_tmo  = 1'b1;
              end_word = mrab_pkg::TIMEOUT_WORD;
            end
          end
        end
      end
      default: begin
        phase_next = mrab_pkg::PHASE_IDLE;
      end
    endcase

    if (end_xfer) begin
      poll_count_next    = '0;
      attempt_count_next = '0;
      if (rmw_pending) begin
        // The read half of a byte write is back: issue the merged word write.
        rmw_pending_next     = 1'b0;
        pending_request_next = mrab_pkg::make_req(pending_request[16:2], 1'b1, merged);
        res.req_value        = pending_request_next;
      end else begin
        phase_next      = mrab_pkg::PHASE_IDLE;
        res.access_done = 1'b1;
        res.read_result = pending_request[1] ? 16'h0000 : rd_sel;
        res.timed_out   = end_tmo;
      end
    end
  end

endmodule

// File: rtl/mrab_out.sv
module mrab_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  mrab_pkg::mrab_out_t res,
  input  logic                result_ready,
  output logic                result_valid,
  output mrab_pkg::mrab_out_t result
);

  // Holds one finished result; a new one may load in the cycle the old one leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= res;
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`default_nettype none

// Self-checking bench for the mailbox RAM access bridge. A directed plan runs
// first, then random host accesses and response polls. Every accepted item
// transaction is run through a local model of the bridge, and each result
// transaction is compared field by field with the oldest outcome still due.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrab_pkg::*;

  localparam int ITEM_TARGET = 1500;  // Random items that the bridge acts on.
  localparam int STEADY_FROM = 1300;  // From here on neither side idles.
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_SETS  = 10;

  // The register index sits in paddr[2]; each register is one 32-bit word.
  localparam logic [2:0] ADDR_POLL_LIMIT  = {REG_POLL_LIMIT, 2'b00};
  localparam logic [2:0] ADDR_RETRY_LIMIT = {REG_RETRY_LIMIT, 2'b00};

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // One line of the directed plan. A row either offers one item transaction
  // or writes one register. When "typed" is set, the outcome is written into
  // the plan by hand and replaces the model's prediction for that row.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  addr;
    logic [31:0] value;
    mrab_in_t    it;
    logic        typed;
    mrab_out_t   want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  mrab_in_t    item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  mrab_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the bridge state and of its two limits.
  phase_t      br_phase = PHASE_IDLE;
  logic [15:0] br_polls = '0;
  logic [2:0]  br_attempts = '0;
  logic [32:0] br_request = '0;
  logic        br_odd = 1'b0;
  logic        br_byte = 1'b0;
  logic [7:0]  br_held = '0;
  logic        br_rmw = 1'b0;
  logic [15:0] cfg_poll_limit = POLL_LIMIT_RESET;
  logic [2:0]  cfg_retry_limit = RETRY_LIMIT_RESET;
  mrab_out_t   pred;

  mrab_out_t   outcomes_due[$];
  mrab_out_t   due_outcome;
  plan_row_t   plan[$];

  int   mismatches = 0;
  int   live_items = 0;
  logic steady = 1'b0;
  logic sender_quiet = 1'b0;
  logic receiver_quiet = 1'b0;
  logic hold_pending = 1'b0;

  mailbox_ram_access_bridge_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #6 clk = ~clk;

  // The request word carries the offset with its lane bit cleared, so that
  // it always names the 16-bit word holding the byte.
  function automatic logic [32:0] pack_request(logic [14:0] off, logic wr, logic [15:0] data);
    return {data, off[14:1], 1'b0, wr, 1'b1};
  endfunction

  function automatic void open_transfer(logic [32:0] req);
    br_request  = req;
    br_polls    = '0;
    br_attempts = '0;
    br_phase    = PHASE_BUSY;
    pred.req_strobe = 1'b1;
    pred.req_value  = req;
  endfunction

  // A transfer has produced its word, either from the response mailbox or as
  // the all-ones word of a timeout. The read half of a byte write does not
  // finish the access: it merges the held byte into the word and issues the
  // write in the same step.
  function automatic void close_transfer(logic [15:0] word, logic expired);
    logic [15:0] merged;
    if (br_rmw) begin
      merged = br_odd ? {word[15:8], br_held} : {br_held, word[7:0]};
      br_rmw = 1'b0;
      open_transfer(pack_request(br_request[16:2], 1'b1, merged));
      return;
    end
    pred.access_done = 1'b1;
    pred.timed_out   = expired;
    // Writes report no data. Byte reads take the high byte at even offsets.
    if (!br_request[1]) begin
      pred.read_result = br_byte ? {8'h00, br_odd ? word[7:0] : word[15:8]} : word;
    end
    br_phase    = PHASE_IDLE;
    br_polls    = '0;
    br_attempts = '0;
  endfunction

  // Works out the result of one item transaction and advances the state.
  function automatic void bridge_outcome(mrab_in_t it);
    int poll_cap;
    int try_cap;
    pred = '0;
    if (it.func == FUNC_ACCESS) begin
      // A host access while a transfer runs is dropped without a trace.
      if (br_phase != PHASE_IDLE) return;
      br_byte = it.access_byte;
      br_odd  = it.offset[0];
      br_held = it.write_data[7:0];
      br_rmw  = it.access_byte & it.access_write;
      if (br_rmw) begin
        open_transfer(pack_request(it.offset, 1'b0, 16'h0000));
      end else begin
        open_transfer(pack_request(it.offset, it.access_write,
                                   it.access_write ? it.write_data : 16'h0000));
      end
      return;
    end
    if (br_phase == PHASE_IDLE) return;
    if (it.rsp_valid) begin
      // The request mailbox is cleared together with the response mailbox.
      pred.req_strobe = 1'b1;
      pred.rsp_clear  = 1'b1;
      close_transfer(it.rsp_data, 1'b0);
      return;
    end
    // A limit written as zero behaves as a limit of one.
    poll_cap = (cfg_poll_limit == '0) ? 1 : int'(cfg_poll_limit);
    try_cap  = (cfg_retry_limit == '0) ? 1 : int'(cfg_retry_limit);
    if (int'(br_polls) + 1 < poll_cap) begin
      br_polls = br_polls + 16'd1;
      return;
    end
    br_polls = '0;
    if (int'(br_attempts) + 1 < try_cap) begin
      br_attempts = br_attempts + 3'd1;
      pred.req_strobe = 1'b1;
      pred.req_value  = br_request;
      return;
    end
    // Out of attempts: the request is withdrawn but the response mailbox is
    // left alone.
    pred.req_strobe = 1'b1;
    close_transfer(TIMEOUT_WORD, 1'b1);
  endfunction

  function automatic mrab_in_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(mrab_in_t)-1:0];
  endfunction

  function automatic mrab_in_t access_item(logic wr, logic byt, logic [14:0] off,
                                           logic [15:0] data);
    mrab_in_t r;
    r = '0;
    r.func         = FUNC_ACCESS;
    r.access_write = wr;
    r.access_byte  = byt;
    r.offset       = off;
    r.write_data   = data;
    return r;
  endfunction

  function automatic mrab_in_t poll_item(logic rsp_valid, logic [15:0] rsp_data);
    mrab_in_t r;
    r = '0;
    r.func      = FUNC_POLL;
    r.rsp_valid = rsp_valid;
    r.rsp_data  = rsp_data;
    return r;
  endfunction

  function automatic mrab_out_t outcome(logic strobe, logic [32:0] req, logic clear,
                                        logic done, logic [15:0] data, logic expired);
    mrab_out_t r;
    r.req_strobe  = strobe;
    r.req_value   = req;
    r.rsp_clear   = clear;
    r.access_done = done;
    r.read_result = data;
    r.timed_out   = expired;
    return r;
  endfunction

  function automatic void plan_item(mrab_in_t it, logic typed, mrab_out_t want);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_ITEM;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endfunction

  function automatic void plan_register(logic [2:0] addr, logic [31:0] value);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.addr  = addr;
    row.value = value;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] wanted);
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, wanted);
    mismatches++;
  endtask

  // Offers one item transaction and holds it until the bridge takes it. An
  // idle burst may come first, unless the sender is in a quiet stretch or the run is steady.
  task automatic send_item(mrab_in_t it, logic typed, mrab_out_t want);
    logic ignored;
    if (!steady && !sender_quiet && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    ignored = (it.func == FUNC_ACCESS) ? (br_phase != PHASE_IDLE) : (br_phase == PHASE_IDLE);
    bridge_outcome(it);
    if (!ignored) live_items++;
    outcomes_due.push_back(typed ? want : pred);
  endtask

  // Stops offering items and waits until every outcome due has arrived, then
  // lets the result path go quiet.
  task automatic settle();
    item_valid <= 1'b0;
    while (outcomes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes a register with a setup and an access phase, then reads it back.
  task automatic set_register(logic [2:0] addr, logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_POLL_LIMIT) begin
      cfg_poll_limit = value[15:0];
    end else begin
      cfg_retry_limit = value[2:0];
    end
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== value) report_mismatch("register readback", readback, value);
  endtask

  // Result side. It idles in random bursts, and once in the run it holds off
  // for a long stretch so that the bridge fills and stalls its item input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
      end else if (!steady && !receiver_quiet && $urandom_range(0, 9) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Every accepted result transaction is matched against the oldest outcome.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (outcomes_due.size() == 0) begin
        report_mismatch("result with nothing due", result, '0);
      end else begin
        due_outcome = outcomes_due.pop_front();
        if (result.req_strobe !== due_outcome.req_strobe)
          report_mismatch("req_strobe", result.req_strobe, due_outcome.req_strobe);
        if (result.req_value !== due_outcome.req_value)
          report_mismatch("req_value", result.req_value, due_outcome.req_value);
        if (result.rsp_clear !== due_outcome.rsp_clear)
          report_mismatch("rsp_clear", result.rsp_clear, due_outcome.rsp_clear);
        if (result.access_done !== due_outcome.access_done)
          report_mismatch("access_done", result.access_done, due_outcome.access_done);
        if (result.read_result !== due_outcome.read_result)
          report_mismatch("read_result", result.read_result, due_outcome.read_result);
        if (result.timed_out !== due_outcome.timed_out)
          report_mismatch("timed_out", result.timed_out, due_outcome.timed_out);
      end
    end
  end

  // Hard stop in case the bridge hangs a handshake.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [15:0] poll_set[PHASE_SETS];
    logic [2:0]  retry_set[PHASE_SETS];
    logic [15:0] poll_pick;
    logic [2:0]  retry_pick;
    mrab_in_t    it;
    int          i;
    int          round;
    int          phase_end;
    int          phase_start;
    int          budget;
    logic        pressure_given;

    poll_set  = '{16'd1, 16'd2, 16'd3, 16'd65535, 16'd1,
                  16'd4, 16'd0, 16'd7, 16'd2, 16'd16};
    retry_set = '{3'd1, 3'd3, 3'd7, 3'd7, 3'd7,
                  3'd2, 3'd0, 3'd1, 3'd5, 3'd4};

    // Directed plan. It starts with the reset limits of 10000 polls and three
    // attempts, so no timeout can occur until the limits are lowered.
    plan_item(poll_item(1'b1, 16'hFFFF), 1'b1, '0);  // poll while idle
    plan_item(access_item(1'b0, 1'b0, 15'h7FFF, 16'hFFFF), 1'b1,
              outcome(1'b1, {16'h0000, 15'h7FFE, 1'b0, 1'b1}, 1'b0, 1'b0, 16'h0, 1'b0));
    plan_item(access_item(1'b1, 1'b1, 15'h0000, 16'hFFFF), 1'b1, '0);  // access while busy
    plan_item(poll_item(1'b0, 16'hFFFF), 1'b1, '0);
    plan_item(poll_item(1'b1, 16'hA5C3), 1'b1,
              outcome(1'b1, '0, 1'b1, 1'b1, 16'hA5C3, 1'b0));
    plan_item(access_item(1'b1, 1'b0, 15'h0000, 16'hFFFF), 1'b1,
              outcome(1'b1, {16'hFFFF, 15'h0000, 1'b1, 1'b1}, 1'b0, 1'b0, 16'h0, 1'b0));
    plan_item(poll_item(1'b1, 16'h1234), 1'b1,
              outcome(1'b1, '0, 1'b1, 1'b1, 16'h0, 1'b0));
    // Byte reads on both lanes, then byte writes as read-modify-write.
    plan_item(access_item(1'b0, 1'b1, 15'h0001, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'hBEEF), 1'b0, '0);
    plan_item(access_item(1'b0, 1'b1, 15'h0002, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'hBEEF), 1'b0, '0);
    plan_item(access_item(1'b1, 1'b1, 15'h0003, 16'h005A), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'h1234), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'h0000), 1'b0, '0);
    plan_item(access_item(1'b1, 1'b1, 15'h7FFE, 16'hFFC3), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'h7777), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'hFFFF), 1'b0, '0);
    // Smallest limits: every silent poll ends the transfer with a timeout.
    plan_register(ADDR_POLL_LIMIT, 32'd1);
    plan_register(ADDR_RETRY_LIMIT, 32'd1);
    plan_item(access_item(1'b0, 1'b0, 15'h1234, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b1,
              outcome(1'b1, '0, 1'b0, 1'b1, TIMEOUT_WORD, 1'b1));
    // A byte write whose read times out merges into the all-ones word.
    plan_item(access_item(1'b1, 1'b1, 15'h0005, 16'h00A5), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b0, '0);
    plan_item(access_item(1'b0, 1'b1, 15'h0006, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b0, '0);
    // Largest limits.
    plan_register(ADDR_POLL_LIMIT, 32'd65535);
    plan_register(ADDR_RETRY_LIMIT, 32'd7);
    plan_item(access_item(1'b1, 1'b0, 15'h0002, 16'h8001), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b1, 16'h0000), 1'b0, '0);
    // Limits of zero behave as limits of one.
    plan_register(ADDR_POLL_LIMIT, 32'd0);
    plan_register(ADDR_RETRY_LIMIT, 32'd0);
    plan_item(access_item(1'b0, 1'b0, 15'h4000, 16'h0000), 1'b0, '0);
    plan_item(poll_item(1'b0, 16'h0000), 1'b1,
              outcome(1'b1, '0, 1'b0, 1'b1, TIMEOUT_WORD, 1'b1));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        set_register(plan[i].addr, plan[i].value);
      end else begin
        send_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    // Random part. Each round sets new limits on an idle bridge, then runs
    // well-formed access/poll sequences with some noise mixed in. The odds of
    // a response per poll are tuned to the limits, so that answered transfers,
    // re-issues and timeouts all occur. Only items the bridge acts on count.
    live_items = 0;
    round = 0;
    pressure_given = 1'b0;
    while (live_items < ITEM_TARGET) begin
      settle();
      if (round < PHASE_SETS) begin
        poll_pick  = poll_set[round];
        retry_pick = retry_set[round];
      end else begin
        poll_pick  = 16'($urandom_range(1, 12));
        retry_pick = 3'($urandom_range(0, 7));
      end
      set_register(ADDR_POLL_LIMIT, {16'h0000, poll_pick});
      set_register(ADDR_RETRY_LIMIT, {29'h0, retry_pick});
      budget = ((poll_pick == '0) ? 1 : int'(poll_pick)) *
               ((retry_pick == '0) ? 1 : int'(retry_pick));
      if (budget > 40) budget = 40;
      steady         = (live_items >= STEADY_FROM);
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      phase_start    = live_items;
      phase_end      = live_items + PHASE_ITEMS;

      while (live_items < phase_end && live_items < ITEM_TARGET) begin
        if (round == 1 && !pressure_given && live_items >= phase_start + 20) begin
          hold_pending   = 1'b1;
          pressure_given = 1'b1;
        end
        it = random_item();
        if ($urandom_range(0, 9) != 0) begin
          // Well-formed traffic: an access when idle, polls while busy.
          if (br_phase == PHASE_IDLE) begin
            it.func = FUNC_ACCESS;
          end else begin
            it.func      = FUNC_POLL;
            it.rsp_valid = ($urandom_range(0, budget) == 0);
          end
        end
        send_item(it, 1'b0, '0);
      end

      // Let any open transfer finish so the next limits go to an idle bridge.
      while (br_phase != PHASE_IDLE) begin
        send_item(poll_item(1'b1, 16'($urandom)), 1'b0, '0);
      end
      round++;
    end

    settle();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
